// ===== rtl/uue_pkg.sv =====
package uue_pkg;

    localparam logic [7:0] ENC_OFFSET = 8'd33;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [2:0] CNT_SINGLE = 3'd1;
    localparam logic [2:0] CNT_GROUP  = 3'd4;

    // 6-bit value to printable character
    function automatic logic [7:0] enc6(input logic [5:0] v);
        return {2'b00, v} + ENC_OFFSET;
    endfunction

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
    } group_chars_t;

endpackage

// ===== rtl/uue_in_if.sv =====
interface uue_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_record;

    modport source (output valid, output data_byte, output end_of_record, input ready);
    modport sink   (input valid, input data_byte, input end_of_record, output ready);
endinterface

// ===== rtl/uue_out_if.sv =====
interface uue_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char0;
    logic [7:0] char1;
    logic [7:0] char2;
    logic [7:0] char3;
    logic [2:0] char_count;
    logic       line_end;

    modport source (output valid, output char0, output char1, output char2, output char3,
                    output char_count, output line_end, input ready);
    modport sink   (input valid, input char0, input char1, input char2, input char3,
                    input char_count, input line_end, output ready);
endinterface

// ===== rtl/uue_group_enc.sv =====
module uue_group_enc
    import uue_pkg::*;
(
    input  logic [7:0]   byte_a,
    input  logic [7:0]   byte_m,
    input  logic [7:0]   byte_z,
    output group_chars_t chars
);

    logic [5:0] v1;
    logic [5:0] v2;
    logic [5:0] v3;
    logic [5:0] v4;

    assign v1 = byte_a[7:2];
    assign v2 = {byte_a[1:0], byte_m[7:4]};
    assign v3 = {byte_m[3:0], byte_z[7:6]};
    assign v4 = byte_z[5:0];

    assign chars.c0 = enc6(v1);
    assign chars.c1 = enc6(v2);
    assign chars.c2 = enc6(v3);
    assign chars.c3 = enc6(v4);

endmodule

// ===== rtl/uuencode_line_encoder_core.sv =====
// Channel   Dir  Payload                                         Transaction
// in_chan   in   data_byte[8], end_of_record                     valid & ready
// out_chan  out  char0..char3[8], char_count[3], line_end        valid & ready
//
// A byte that does not close a line is stored, and in_chan stays ready.
// A closing byte starts a line dump: header, then for each 3-byte group three reads
// through the single line-buffer read port and one encode, then newline; out_chan
// back-pressure holds the dump in the header, group or newline state.
// in_chan is not ready during a dump. Reset clears the fill count and sequencer;
// buffer contents are never cleared.
module uuencode_line_encoder_core
    import uue_pkg::*;
#(
    parameter int LINE_BYTES = 60
)
(
    input  logic            clk,
    input  logic            rst_n,
    uue_in_if.sink          in_chan,
    uue_out_if.source       out_chan
);

    localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int NW = $clog2(LINE_BYTES + 1);
    localparam int PW = $clog2(LINE_BYTES + 3);

    localparam logic [1:0] SUB_A = 2'd0;
    localparam logic [1:0] SUB_M = 2'd1;
    localparam logic [1:0] SUB_Z = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HDR  = 5'b00010,
        S_RD   = 5'b00100,
        S_GRP  = 5'b01000,
        S_NL   = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   fill_reg, fill_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [1:0]      sub_reg, sub_next;
    logic [7:0]      a_reg, a_next;
    logic [7:0]      m_reg, m_next;

    logic            out_valid_reg, out_valid_next;
    logic [7:0]      c0_reg, c0_next;
    logic [7:0]      c1_reg, c1_next;
    logic [7:0]      c2_reg, c2_next;
    logic [7:0]      c3_reg, c3_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic            end_reg, end_next;

    logic [7:0]      store_mem [LINE_BYTES];
    logic [7:0]      rd_data_reg;

    logic            in_xact;
    logic            out_free;
    logic [NW-1:0]   n_new;
    logic [PW-1:0]   rd_addr_full;
    logic            rd_en;
    logic [PW-1:0]   pos_p3;
    logic [7:0]      m_masked;
    logic [7:0]      z_masked;
    group_chars_t    grp_chars;

    assign in_chan.ready = (state_reg == S_IDLE);
    assign in_xact       = in_chan.valid && in_chan.ready;
    assign out_free      = !out_valid_reg || out_chan.ready;
    assign n_new         = NW'(fill_reg) + NW'(1);
    assign rd_addr_full  = pos_reg + PW'(sub_reg);
    assign rd_en         = (state_reg == S_RD) && (rd_addr_full < PW'(LINE_BYTES));
    assign pos_p3        = pos_reg + PW'(3);

    // bytes past the end of the line count as zero
    assign m_masked = ((pos_reg + PW'(1)) < PW'(n_reg)) ? m_reg : 8'd0;
    assign z_masked = ((pos_reg + PW'(2)) < PW'(n_reg)) ? rd_data_reg : 8'd0;

    uue_group_enc u_enc (
        .byte_a (a_reg),
        .byte_m (m_masked),
        .byte_z (z_masked),
        .chars  (grp_chars)
    );

    always_ff @(posedge clk)
    begin
        if (in_xact)
        begin
            store_mem[fill_reg] <= in_chan.data_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr_full[AW-1:0]];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        n_next         = n_reg;
        pos_next       = pos_reg;
        sub_next       = sub_reg;
        a_next         = a_reg;
        m_next         = m_reg;
        out_valid_next = out_valid_reg && !out_chan.ready;
        c0_next        = c0_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        c3_next        = c3_reg;
        cnt_next       = cnt_reg;
        end_next       = end_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xact)
                begin
                    if ((n_new == NW'(LINE_BYTES)) || in_chan.end_of_record)
                    begin
                        n_next     = n_new;
                        fill_next  = '0;
                        state_next = S_HDR;
                    end
                    else
                    begin
                        fill_next = AW'(n_new);
                    end
                end
            end
            S_HDR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    c0_next        = enc6(6'(n_reg));
                    c1_next        = 8'd0;
                    c2_next        = 8'd0;
                    c3_next        = 8'd0;
                    cnt_next       = CNT_SINGLE;
                    end_next       = 1'b0;
                    pos_next       = '0;
                    sub_next       = SUB_A;
                    state_next     = S_RD;
                end
            end
            S_RD:
            begin
                // read data is registered and arrives in the cycle after its address
                if (sub_reg == SUB_M)
                begin
                    a_next = rd_data_reg;
                end
                if (sub_reg == SUB_Z)
                begin
                    m_next     = rd_data_reg;
                    state_next = S_GRP;
                end
                else
                begin
                    sub_next = sub_reg + 2'd1;
                end
            end
            S_GRP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    c0_next        = grp_chars.c0;
                    c1_next        = grp_chars.c1;
                    c2_next        = grp_chars.c2;
                    c3_next        = grp_chars.c3;
                    cnt_next       = CNT_GROUP;
                    end_next       = 1'b0;
                    pos_next       = pos_p3;
                    sub_next       = SUB_A;
                    state_next     = (pos_p3 >= PW'(n_reg)) ? S_NL : S_RD;
                end
            end
            S_NL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    c0_next        = CHAR_NL;
                    c1_next        = 8'd0;
                    c2_next        = 8'd0;
                    c3_next        = 8'd0;
                    cnt_next       = CNT_SINGLE;
                    end_next       = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        pos_reg <= pos_next;
        sub_reg <= sub_next;
        a_reg   <= a_next;
        m_reg   <= m_next;
        c0_reg  <= c0_next;
        c1_reg  <= c1_next;
        c2_reg  <= c2_next;
        c3_reg  <= c3_next;
        cnt_reg <= cnt_next;
        end_reg <= end_next;
    end

    assign out_chan.valid      = out_valid_reg;
    assign out_chan.char0      = c0_reg;
    assign out_chan.char1      = c1_reg;
    assign out_chan.char2      = c2_reg;
    assign out_chan.char3      = c3_reg;
    assign out_chan.char_count = cnt_reg;
    assign out_chan.line_end   = end_reg;

endmodule

// ===== rtl/uue_checker.sv =====
module uue_checker
    import uue_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] char0,
    input logic [7:0] char1,
    input logic [2:0] char_count,
    input logic       line_end
);

    // a stalled output transaction holds char0, char_count and line_end
    ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char0) && $stable(char_count)
                                    && $stable(line_end))
        else $error("output payload changed under stall");

    ap_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_count == CNT_SINGLE) || (char_count == CNT_GROUP))
        else $error("bad char_count");

    ap_newline: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_end |-> (char_count == CNT_SINGLE) && (char0 == CHAR_NL))
        else $error("line end item is not a newline");

    // the first two group characters stay in the printable range
    ap_group_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (char_count == CNT_GROUP) |->
            (char0 >= ENC_OFFSET) && (char0 <= ENC_OFFSET + 8'd63)
            && (char1 >= ENC_OFFSET) && (char1 <= ENC_OFFSET + 8'd63))
        else $error("group character out of range");

    // input is held off while a header is still pending on the output
    ap_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_end && (char_count == CNT_SINGLE) |-> !in_ready)
        else $error("unexpected input handshake");

endmodule

bind uuencode_line_encoder_core uue_checker u_uue_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .char0      (out_chan.char0),
    .char1      (out_chan.char1),
    .char_count (out_chan.char_count),
    .line_end   (out_chan.line_end)
);
